// ----- rtl/rnd_pkg.sv -----
// ----------------------------------------------------------------------------
// rnd_pkg
// Shared types and constants for the RTP H.264 NAL depacketizer.
// ----------------------------------------------------------------------------
package rnd_pkg;

	localparam logic [4:0] TYPE_FU_A   = 5'd28;
	localparam logic [4:0] TYPE_STAP_A = 5'd24;
	localparam logic [4:0] TYPE_SPS    = 5'd7;
	localparam logic [4:0] TYPE_PPS    = 5'd8;
	localparam logic [7:0] NRI_MASK    = 8'hE0;
	localparam logic [7:0] TYPE_MASK   = 8'h1F;
	localparam int         FU_START_BIT = 7;
	localparam int         FU_END_BIT   = 6;

	localparam logic [15:0] OFFSET_MAX = 16'hFFFF;

	// packet kinds
	localparam logic [1:0] KIND_SINGLE   = 2'd0;
	localparam logic [1:0] KIND_FU       = 2'd1;
	localparam logic [1:0] KIND_STAP     = 2'd2;
	localparam logic [1:0] KIND_STAP_LOW = 2'd3;

	// request codes
	localparam logic REQ_BYTE  = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] data_out;
		logic       unit_end;
		logic       discard;
		logic       sps_seen;
		logic       pps_seen;
	} rnd_result_t;

endpackage

// ----- rtl/rnd_front.sv -----
// ----------------------------------------------------------------------------
// rnd_front
// Classifies each payload byte, tracks packet state and builds result words.
// ----------------------------------------------------------------------------
module rnd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               req_type,
	input  logic [7:0]         data_in,
	input  logic               first_byte,
	input  logic               last_byte,
	input  logic [15:0]        packet_len,
	output logic               res_valid,
	output rnd_pkg::rnd_result_t res
);
	import rnd_pkg::*;

	logic [1:0]  kind_q;
	logic [15:0] offset_q;
	logic [7:0]  ind_q;
	logic        frag_open_q;
	logic        frag_end_q;
	logic [15:0] remaining_q;
	logic [7:0]  size_hi_q;
	logic        agg_stop_q;
	logic        sps_q;
	logic        pps_q;

	logic [1:0]  kind_n;
	logic [15:0] offset_n;
	logic [7:0]  ind_n;
	logic        frag_open_n;
	logic        frag_end_n;
	logic [15:0] remaining_n;
	logic [7:0]  size_hi_n;
	logic        agg_stop_n;
	logic        sps_n;
	logic        pps_n;

	logic [15:0] pos;
	logic        pos0;
	logic [4:0]  nal_type;
	logic [15:0] unit_size;
	logic [17:0] unit_span;
	logic [16:0] hdr_span;
	logic        has;
	logic        uend;
	logic        disc;
	logic [7:0]  dout;

	assign pos       = first_byte ? '0 : offset_q;
	assign pos0      = (pos == '0);
	assign nal_type  = data_in[4:0];
	assign unit_size = {size_hi_q, data_in};
	assign unit_span = {2'b00, pos} + 18'd1 + {2'b00, unit_size};
	assign hdr_span  = {1'b0, pos} + 17'd2;

	always_comb begin
		kind_n      = kind_q;
		offset_n    = offset_q;
		ind_n       = ind_q;
		frag_open_n = frag_open_q;
		frag_end_n  = frag_end_q;
		remaining_n = remaining_q;
		size_hi_n   = size_hi_q;
		agg_stop_n  = agg_stop_q;
		sps_n       = sps_q;
		pps_n       = pps_q;
		has         = 1'b0;
		uend        = 1'b0;
		disc        = 1'b0;
		dout        = data_in;

		if (req_type == REQ_CLEAR) begin
			disc        = frag_open_q;
			kind_n      = KIND_SINGLE;
			offset_n    = '0;
			ind_n       = '0;
			frag_open_n = 1'b0;
			frag_end_n  = 1'b0;
			remaining_n = '0;
			size_hi_n   = '0;
			agg_stop_n  = 1'b0;
			sps_n       = 1'b0;
			pps_n       = 1'b0;
		end else begin
			if (pos0) begin
				remaining_n = '0;
				agg_stop_n  = 1'b0;
				if (nal_type == TYPE_FU_A) begin
					kind_n = KIND_FU;
				end else begin
					kind_n = (nal_type == TYPE_STAP_A) ? KIND_STAP : KIND_SINGLE;
					// a non-fragment packet cuts off an open fragment
					if (frag_open_q) begin
						disc        = 1'b1;
						frag_open_n = 1'b0;
					end
				end
			end

			unique case (kind_n)
				KIND_SINGLE: begin
					if (pos0) begin
						if (nal_type == TYPE_SPS) sps_n = 1'b1;
						if (nal_type == TYPE_PPS) pps_n = 1'b1;
					end
					has  = 1'b1;
					uend = last_byte;
				end
				KIND_FU: begin
					if (pos0) begin
						ind_n = data_in;
					end else if (pos == 16'd1) begin
						frag_end_n = data_in[FU_END_BIT];
						if (data_in[FU_START_BIT]) begin
							disc        = disc | frag_open_n;
							frag_open_n = 1'b1;
							dout        = (ind_q & NRI_MASK) | (data_in & TYPE_MASK);
							has         = 1'b1;
						end
					end else if (frag_open_n) begin
						has = 1'b1;
					end
					if (!pos0 && frag_open_n && last_byte && frag_end_n) begin
						uend        = 1'b1;
						frag_open_n = 1'b0;
					end
				end
				KIND_STAP, KIND_STAP_LOW: begin
					if (!pos0 && !agg_stop_n) begin
						if (kind_n == KIND_STAP_LOW) begin
							kind_n = KIND_STAP;
							if (unit_span > {2'b00, packet_len})
								agg_stop_n = 1'b1;
							else
								remaining_n = unit_size;
						end else if (remaining_n != '0) begin
							has         = 1'b1;
							remaining_n = remaining_n - 16'd1;
						end else if (hdr_span < {1'b0, packet_len}) begin
							size_hi_n = data_in;
							kind_n    = KIND_STAP_LOW;
						end else begin
							agg_stop_n = 1'b1;
						end
					end
					uend = last_byte;
				end
				default: begin
					has = 1'b0;
				end
			endcase

			offset_n = (pos < OFFSET_MAX) ? pos + 16'd1 : OFFSET_MAX;
		end
	end

	assign res_valid    = accept & (has | uend | disc);
	assign res.has_byte = has;
	assign res.data_out = has ? dout : 8'h00;
	assign res.unit_end = uend;
	assign res.discard  = disc;
	assign res.sps_seen = sps_n;
	assign res.pps_seen = pps_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= KIND_SINGLE;
			offset_q    <= '0;
			ind_q       <= '0;
			frag_open_q <= 1'b0;
			frag_end_q  <= 1'b0;
			remaining_q <= '0;
			size_hi_q   <= '0;
			agg_stop_q  <= 1'b0;
			sps_q       <= 1'b0;
			pps_q       <= 1'b0;
		end else if (accept) begin
			kind_q      <= kind_n;
			offset_q    <= offset_n;
			ind_q       <= ind_n;
			frag_open_q <= frag_open_n;
			frag_end_q  <= frag_end_n;
			remaining_q <= remaining_n;
			size_hi_q   <= size_hi_n;
			agg_stop_q  <= agg_stop_n;
			sps_q       <= sps_n;
			pps_q       <= pps_n;
		end
	end

endmodule

// ----- rtl/rnd_queue.sv -----
// ----------------------------------------------------------------------------
// rnd_queue
// Short result queue between the classifier and the output side.
// ----------------------------------------------------------------------------
module rnd_queue #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  rnd_pkg::rnd_result_t wr_word,
	input  logic                 rd_en,
	output rnd_pkg::rnd_result_t rd_word,
	output logic                 q_empty,
	output logic                 q_full
);
	import rnd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	rnd_result_t       slot_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_wr;
	logic              do_rd;

	assign do_wr   = wr_en && (count_q != FULL_CNT);
	assign do_rd   = rd_en && (count_q != '0);
	assign q_empty = (count_q == '0);
	assign q_full  = (count_q == FULL_CNT);
	assign rd_word = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wr_ptr_q] <= wr_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

// ----- rtl/rtp_h264_nal_depacketizer_top.sv -----
// ----------------------------------------------------------------------------
// rtp_h264_nal_depacketizer_top
// Streams RTP H.264 payload bytes into rebuilt NAL unit bytes.
// ----------------------------------------------------------------------------
// Takes one payload byte per cycle and sustains that rate indefinitely while
// the result side keeps popping. Each byte is classified and its result word
// formed in the same cycle it is pushed; the word is registered in the result
// queue and shows on the result ports once it is at its head. Bytes that produce
// no word (FU indicators, STAP-A size bytes, dropped bytes) are still taken in.
// full rises only when the DEPTH-entry result queue is full, so the result side
// may stall for up to DEPTH words before the input side sees back-pressure.
module rtp_h264_nal_depacketizer_top #(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        req_type,
	input  logic [7:0]  data_in,
	input  logic        first_byte,
	input  logic        last_byte,
	input  logic [15:0] packet_len,
	output logic        empty,
	input  logic        pop,
	output logic        has_byte,
	output logic [7:0]  data_out,
	output logic        unit_end,
	output logic        discard,
	output logic        sps_seen,
	output logic        pps_seen
);
	import rnd_pkg::*;

	logic        accept;
	logic        res_valid;
	rnd_result_t res;
	rnd_result_t head;

	assign accept = push & ~full;

	rnd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req_type   (req_type),
		.data_in    (data_in),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.packet_len (packet_len),
		.res_valid  (res_valid),
		.res        (res)
	);

	rnd_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_word (res),
		.rd_en   (pop),
		.rd_word (head),
		.q_empty (empty),
		.q_full  (full)
	);

	assign has_byte = head.has_byte;
	assign data_out = head.data_out;
	assign unit_end = head.unit_end;
	assign discard  = head.discard;
	assign sps_seen = head.sps_seen;
	assign pps_seen = head.pps_seen;

endmodule

// ----- rtl/rnd_checker.sv -----
// ----------------------------------------------------------------------------
// rnd_checker
// Port-level checks for the depacketizer, bound to the top level.
// ----------------------------------------------------------------------------
module rnd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic       has_byte,
	input logic [7:0] data_out,
	input logic       unit_end,
	input logic       discard,
	input logic       sps_seen,
	input logic       pps_seen
);

	// a word is only queued when it carries something
	a_word_meaningful: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (has_byte || unit_end || discard))
		else $error("result word with no byte, end or discard");

	// byte lane is zero when no byte is carried
	a_idle_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !has_byte) |-> (data_out == 8'h00))
		else $error("data_out nonzero without has_byte");

	a_head_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("waiting word vanished");

	a_head_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(data_out) && $stable(has_byte) &&
			$stable(unit_end) && $stable(discard) &&
			$stable(sps_seen) && $stable(pps_seen)))
		else $error("waiting word changed");

endmodule

bind rtp_h264_nal_depacketizer_top rnd_checker u_rnd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.has_byte (has_byte),
	.data_out (data_out),
	.unit_end (unit_end),
	.discard  (discard),
	.sps_seen (sps_seen),
	.pps_seen (pps_seen)
);
